// File: rtl/lavm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and fixed widths of the look-at view matrix core.
// ----------------------------------------------------------------------------
package lavm_pkg;

    // Field width of every coordinate word
    localparam int XW    = 32;
    // Gaze difference center - eye
    localparam int GW    = XW + 1;
    // Cross product before normalization
    localparam int CW    = XW + 2;
    // Multiplier operand and accumulator
    localparam int MW    = CW;
    localparam int AW    = 2 * MW;
    // Sum of three squares and its floor root
    localparam int RADW  = 66;
    localparam int ROOTW = RADW / 2;
    // Depth of the job queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic signed [XW-1:0] eye_x;
        logic signed [XW-1:0] eye_y;
        logic signed [XW-1:0] eye_z;
        logic signed [XW-1:0] center_x;
        logic signed [XW-1:0] center_y;
        logic signed [XW-1:0] center_z;
        logic signed [XW-1:0] up_x;
        logic signed [XW-1:0] up_y;
        logic signed [XW-1:0] up_z;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [XW-1:0] col_zero;
        logic signed [XW-1:0] col_one;
        logic signed [XW-1:0] col_two;
        logic signed [XW-1:0] col_three;
        logic                 last_row;
        logic                 degenerate;
    } t_result;

    // Classified job as handed from front to back
    typedef struct packed {
        logic signed [XW-1:0] eye_x;
        logic signed [XW-1:0] eye_y;
        logic signed [XW-1:0] eye_z;
        logic signed [XW-1:0] up_x;
        logic signed [XW-1:0] up_y;
        logic signed [XW-1:0] up_z;
        logic signed [GW-1:0] g_x;
        logic signed [GW-1:0] g_y;
        logic signed [GW-1:0] g_z;
        logic                 g_zero;
    } t_job;

endpackage
`default_nettype wire

// File: rtl/lavm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_front
// Input stage: take a word, form the gaze and flag a zero gaze.
// ----------------------------------------------------------------------------
module lavm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire lavm_pkg::t_cmd i_cmd,
    input  wire logic           i_full,
    output logic                o_busy,
    output logic                o_push,
    output lavm_pkg::t_job      o_job
);

    logic           r_valid;
    lavm_pkg::t_job r_job;
    lavm_pkg::t_job n_job;
    logic           accept;

    assign o_busy = r_valid & i_full;
    assign o_push = r_valid & ~i_full;
    assign accept = i_start & ~o_busy;
    assign o_job  = r_job;

    always_comb begin
        n_job.eye_x = i_cmd.eye_x;
        n_job.eye_y = i_cmd.eye_y;
        n_job.eye_z = i_cmd.eye_z;
        n_job.up_x  = i_cmd.up_x;
        n_job.up_y  = i_cmd.up_y;
        n_job.up_z  = i_cmd.up_z;
        n_job.g_x   = lavm_pkg::GW'(i_cmd.center_x) - lavm_pkg::GW'(i_cmd.eye_x);
        n_job.g_y   = lavm_pkg::GW'(i_cmd.center_y) - lavm_pkg::GW'(i_cmd.eye_y);
        n_job.g_z   = lavm_pkg::GW'(i_cmd.center_z) - lavm_pkg::GW'(i_cmd.eye_z);
        n_job.g_zero = (i_cmd.center_x == i_cmd.eye_x) && (i_cmd.center_y == i_cmd.eye_y)
                       && (i_cmd.center_z == i_cmd.eye_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lavm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_queue
// Short job queue that lets front and back stall on their own.
// ----------------------------------------------------------------------------
module lavm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lavm_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output lavm_pkg::t_job      o_job
);

    localparam int QPW = $clog2(lavm_pkg::QDEPTH);
    localparam int QCW = $clog2(lavm_pkg::QDEPTH + 1);

    lavm_pkg::t_job r_mem [lavm_pkg::QDEPTH];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(lavm_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // depth is a power of two: pointers wrap on overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lavm_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_isqrt
// Floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module lavm_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lavm_pkg::RADW-1:0]   i_rad,
    output logic                             o_done,
    output logic [lavm_pkg::ROOTW-1:0]       o_root
);

    localparam int RW   = lavm_pkg::ROOTW;
    localparam int RMW  = RW + 4;
    localparam int CNTW = $clog2(RW);

    logic                        r_run;
    logic                        r_done;
    logic [CNTW-1:0]             r_cnt;
    logic [lavm_pkg::RADW-1:0]   r_rad;
    logic [RMW-1:0]              r_rem;
    logic [RW-1:0]               r_root;
    logic [RMW-1:0]              rem_s;
    logic [RMW-1:0]              trial;
    logic                        ge;

    assign rem_s  = {r_rem[RMW-3:0], r_rad[lavm_pkg::RADW-1 -: 2]};
    assign trial  = {{(RMW-RW-2){1'b0}}, r_root, 2'b01};
    assign ge     = (rem_s >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(RW - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad  <= {r_rad[lavm_pkg::RADW-3:0], 2'b00};
            r_rem  <= ge ? (rem_s - trial) : rem_s;
            r_root <= {r_root[RW-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: rtl/lavm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_div
// Normalizing divide (x << FRAC_BITS) / norm, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lavm_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [lavm_pkg::CW-1:0]    i_num,
    input  wire logic [lavm_pkg::ROOTW-1:0]        i_den,
    input  wire logic                              i_neg,
    output logic                                   o_done,
    output logic signed [FRAC_BITS+2:0]            o_quo
);

    localparam int CW   = lavm_pkg::CW;
    localparam int RW   = CW + FRAC_BITS;
    localparam int QB   = FRAC_BITS + 1;
    localparam int VW   = FRAC_BITS + 3;
    localparam int CNTW = $clog2(QB);

    logic                 r_run;
    logic                 r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_dsh;
    logic [QB-1:0]        r_q;
    logic                 r_sgn;
    logic [CW-1:0]        mag;
    logic                 ge;
    logic signed [VW-1:0] qx;

    assign mag    = i_num[CW-1] ? CW'(-i_num) : CW'(i_num);
    assign ge     = (r_rem >= r_dsh);
    assign qx     = {2'b00, r_q};
    assign o_quo  = r_sgn ? -qx : qx;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(FRAC_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient stays below 2^(FRAC_BITS+1) since |x| never exceeds the norm
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {mag, {FRAC_BITS{1'b0}}};
            r_dsh <= {1'b0, i_den, {FRAC_BITS{1'b0}}};
            r_q   <= '0;
            r_sgn <= i_num[CW-1] ^ i_neg;
        end else if (r_run) begin
            r_rem <= ge ? (r_rem - r_dsh) : r_rem;
            r_dsh <= {1'b0, r_dsh[RW-1:1]};
            r_q   <= {r_q[QB-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: rtl/lavm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_back
// Sequencer with one shared MAC, root and divide units; emits the rows.
// ----------------------------------------------------------------------------
module lavm_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire lavm_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output lavm_pkg::t_result   o_result
);

    localparam int XW    = lavm_pkg::XW;
    localparam int GW    = lavm_pkg::GW;
    localparam int CW    = lavm_pkg::CW;
    localparam int MW    = lavm_pkg::MW;
    localparam int AW    = lavm_pkg::AW;
    localparam int VW    = FRAC_BITS + 3;
    localparam int KW    = 4;
    localparam logic [KW-1:0] K_SQ_LAST = KW'(3);
    localparam logic [KW-1:0] K_CR_LAST = KW'(6);
    localparam logic [KW-1:0] K_TR_LAST = KW'(9);
    localparam logic [KW-1:0] K_V_LAST  = KW'(2);
    localparam logic [KW-1:0] K_ROW_LAST = KW'(3);
    localparam logic [XW-1:0] ONE_FX    = XW'(1) << FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SQG  = 11'b000_0000_0010,
        S_RTG  = 11'b000_0000_0100,
        S_DVW  = 11'b000_0000_1000,
        S_CRC  = 11'b000_0001_0000,
        S_SQC  = 11'b000_0010_0000,
        S_RTC  = 11'b000_0100_0000,
        S_DVU  = 11'b000_1000_0000,
        S_CRV  = 11'b001_0000_0000,
        S_TRN  = 11'b010_0000_0000,
        S_EMIT = 11'b100_0000_0000
    } t_state;

    t_state                        r_state;
    logic [KW-1:0]                 r_k;
    logic                          r_iss;
    logic                          r_degen;
    logic signed [XW-1:0]          r_eye [3];
    logic signed [XW-1:0]          r_up  [3];
    logic signed [XW-1:0]          r_t   [3];
    logic signed [GW-1:0]          r_g   [3];
    logic signed [CW-1:0]          r_c   [3];
    logic signed [VW-1:0]          r_w   [3];
    logic signed [VW-1:0]          r_u   [3];
    logic signed [VW-1:0]          r_v   [3];
    logic [lavm_pkg::ROOTW-1:0]    r_nrm;
    logic signed [AW-1:0]          r_acc;
    logic                          r_valid;
    lavm_pkg::t_result             r_res;
    lavm_pkg::t_result             n_res;

    logic signed [MW-1:0]          pa [3];
    logic signed [MW-1:0]          pb [3];
    logic signed [MW-1:0]          ma;
    logic signed [MW-1:0]          mb;
    logic                          neg;
    logic                          clr;
    logic                          mac_en;
    logic signed [AW-1:0]          prod;
    logic signed [AW-1:0]          sh;
    logic signed [XW-1:0]          sat;
    logic                          sat_hi;
    logic                          sat_lo;

    logic                          sq_start;
    logic                          sq_done;
    logic [lavm_pkg::ROOTW-1:0]    sq_root;
    logic                          dv_start;
    logic                          dv_done;
    logic signed [CW-1:0]          dv_num;
    logic signed [VW-1:0]          dv_quo;

    function automatic logic signed [MW-1:0] ext_x(input logic signed [XW-1:0] x);
        return {{(MW-XW){x[XW-1]}}, x};
    endfunction

    function automatic logic signed [MW-1:0] ext_g(input logic signed [GW-1:0] x);
        return {{(MW-GW){x[GW-1]}}, x};
    endfunction

    function automatic logic signed [MW-1:0] ext_v(input logic signed [VW-1:0] x);
        return {{(MW-VW){x[VW-1]}}, x};
    endfunction

    function automatic logic signed [XW-1:0] v2x(input logic signed [VW-1:0] x);
        return {{(XW-VW){x[VW-1]}}, x};
    endfunction

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // ---- MAC operand selection ----
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa[i] = '0;
            pb[i] = '0;
        end
        case (r_state)
            S_CRC: begin
                for (int i = 0; i < 3; i++) begin
                    pa[i] = ext_x(r_up[i]);
                    pb[i] = ext_v(r_w[i]);
                end
            end
            S_CRV: begin
                for (int i = 0; i < 3; i++) begin
                    pa[i] = ext_v(r_w[i]);
                    pb[i] = ext_v(r_u[i]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ma     = '0;
        mb     = '0;
        neg    = 1'b0;
        clr    = 1'b0;
        mac_en = 1'b0;
        case (r_state)
            S_SQG, S_SQC: begin
                mac_en = (r_k < K_SQ_LAST);
                clr    = (r_k == '0);
                case (r_k)
                    KW'(0): begin
                        ma = (r_state == S_SQG) ? ext_g(r_g[0]) : r_c[0];
                    end
                    KW'(1): begin
                        ma = (r_state == S_SQG) ? ext_g(r_g[1]) : r_c[1];
                    end
                    KW'(2): begin
                        ma = (r_state == S_SQG) ? ext_g(r_g[2]) : r_c[2];
                    end
                    default: begin
                    end
                endcase
                mb = ma;
            end
            S_CRC, S_CRV: begin
                mac_en = (r_k < K_CR_LAST);
                clr    = ~r_k[0];
                neg    = r_k[0];
                case (r_k)
                    KW'(0): begin ma = pa[1]; mb = pb[2]; end
                    KW'(1): begin ma = pa[2]; mb = pb[1]; end
                    KW'(2): begin ma = pa[2]; mb = pb[0]; end
                    KW'(3): begin ma = pa[0]; mb = pb[2]; end
                    KW'(4): begin ma = pa[0]; mb = pb[1]; end
                    KW'(5): begin ma = pa[1]; mb = pb[0]; end
                    default: begin
                    end
                endcase
            end
            S_TRN: begin
                // accumulate minus the dot product directly
                mac_en = (r_k < K_TR_LAST);
                neg    = 1'b1;
                clr    = (r_k == KW'(0)) || (r_k == KW'(3)) || (r_k == KW'(6));
                case (r_k)
                    KW'(0): begin ma = ext_x(r_eye[0]); mb = ext_v(r_u[0]); end
                    KW'(1): begin ma = ext_x(r_eye[1]); mb = ext_v(r_u[1]); end
                    KW'(2): begin ma = ext_x(r_eye[2]); mb = ext_v(r_u[2]); end
                    KW'(3): begin ma = ext_x(r_eye[0]); mb = ext_v(r_v[0]); end
                    KW'(4): begin ma = ext_x(r_eye[1]); mb = ext_v(r_v[1]); end
                    KW'(5): begin ma = ext_x(r_eye[2]); mb = ext_v(r_v[2]); end
                    KW'(6): begin ma = ext_x(r_eye[0]); mb = ext_v(r_w[0]); end
                    KW'(7): begin ma = ext_x(r_eye[1]); mb = ext_v(r_w[1]); end
                    KW'(8): begin ma = ext_x(r_eye[2]); mb = ext_v(r_w[2]); end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign prod = ma * mb;

    // ---- write-back shaping: floor shift, then saturation ----
    assign sh     = r_acc >>> FRAC_BITS;
    assign sat_hi = !sh[AW-1] && (|sh[AW-2:XW-1]);
    assign sat_lo = sh[AW-1] && !(&sh[AW-2:XW-1]);
    assign sat    = sat_hi ? {1'b0, {(XW-1){1'b1}}} :
                    sat_lo ? {1'b1, {(XW-1){1'b0}}} : sh[XW-1:0];

    // ---- root and divide units ----
    assign sq_start = ((r_state == S_SQG) || (r_state == S_SQC)) && (r_k == K_SQ_LAST);
    assign dv_start = ((r_state == S_DVW) || (r_state == S_DVU)) && !r_iss;

    always_comb begin
        dv_num = '0;
        case (r_k[1:0])
            2'd0:    dv_num = (r_state == S_DVW) ? ext_g(r_g[0]) : r_c[0];
            2'd1:    dv_num = (r_state == S_DVW) ? ext_g(r_g[1]) : r_c[1];
            2'd2:    dv_num = (r_state == S_DVW) ? ext_g(r_g[2]) : r_c[2];
            default: dv_num = '0;
        endcase
    end

    lavm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc[lavm_pkg::RADW-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    lavm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (r_nrm),
        .i_neg   (r_state == S_DVW),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    // ---- row builder ----
    always_comb begin
        n_res.row_index  = r_k[1:0];
        n_res.last_row   = 1'b0;
        n_res.degenerate = r_degen;
        n_res.col_zero   = '0;
        n_res.col_one    = '0;
        n_res.col_two    = '0;
        n_res.col_three  = '0;
        case (r_k[1:0])
            2'd0: begin
                if (r_degen) begin
                    n_res.col_zero = ONE_FX;
                end else begin
                    n_res.col_zero  = v2x(r_u[0]);
                    n_res.col_one   = v2x(r_u[1]);
                    n_res.col_two   = v2x(r_u[2]);
                    n_res.col_three = r_t[0];
                end
            end
            2'd1: begin
                if (r_degen) begin
                    n_res.col_one = ONE_FX;
                end else begin
                    n_res.col_zero  = v2x(r_v[0]);
                    n_res.col_one   = v2x(r_v[1]);
                    n_res.col_two   = v2x(r_v[2]);
                    n_res.col_three = r_t[1];
                end
            end
            2'd2: begin
                if (r_degen) begin
                    n_res.col_two = ONE_FX;
                end else begin
                    n_res.col_zero  = v2x(r_w[0]);
                    n_res.col_one   = v2x(r_w[1]);
                    n_res.col_two   = v2x(r_w[2]);
                    n_res.col_three = r_t[2];
                end
            end
            default: begin
                n_res.col_three = ONE_FX;
                n_res.last_row  = 1'b1;
            end
        endcase
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_iss   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (mac_en) begin
                r_acc <= (clr ? '0 : r_acc) + (neg ? -prod : prod);
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_eye[0] <= i_job.eye_x;
                        r_eye[1] <= i_job.eye_y;
                        r_eye[2] <= i_job.eye_z;
                        r_up[0]  <= i_job.up_x;
                        r_up[1]  <= i_job.up_y;
                        r_up[2]  <= i_job.up_z;
                        r_g[0]   <= i_job.g_x;
                        r_g[1]   <= i_job.g_y;
                        r_g[2]   <= i_job.g_z;
                        r_degen  <= i_job.g_zero;
                        r_k      <= '0;
                        // zero gaze: skip straight to identity rows
                        r_state  <= i_job.g_zero ? S_EMIT : S_SQG;
                    end
                end
                S_SQG, S_SQC: begin
                    if (r_k == K_SQ_LAST) begin
                        r_state <= (r_state == S_SQG) ? S_RTG : S_RTC;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_RTG, S_RTC: begin
                    if (sq_done) begin
                        r_nrm   <= sq_root;
                        r_k     <= '0;
                        r_iss   <= 1'b0;
                        r_state <= (r_state == S_RTG) ? S_DVW : S_DVU;
                    end
                end
                S_DVW, S_DVU: begin
                    if (dv_done) begin
                        case (r_k[1:0])
                            2'd0: begin
                                if (r_state == S_DVW) r_w[0] <= dv_quo;
                                else                  r_u[0] <= dv_quo;
                            end
                            2'd1: begin
                                if (r_state == S_DVW) r_w[1] <= dv_quo;
                                else                  r_u[1] <= dv_quo;
                            end
                            default: begin
                                if (r_state == S_DVW) r_w[2] <= dv_quo;
                                else                  r_u[2] <= dv_quo;
                            end
                        endcase
                        r_iss <= 1'b0;
                        if (r_k == K_V_LAST) begin
                            r_k     <= '0;
                            r_state <= (r_state == S_DVW) ? S_CRC : S_CRV;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end else if (!r_iss) begin
                        r_iss <= 1'b1;
                    end
                end
                S_CRC, S_CRV: begin
                    case (r_k)
                        KW'(2): begin
                            if (r_state == S_CRC) r_c[0] <= sh[CW-1:0];
                            else                  r_v[0] <= sh[VW-1:0];
                        end
                        KW'(4): begin
                            if (r_state == S_CRC) r_c[1] <= sh[CW-1:0];
                            else                  r_v[1] <= sh[VW-1:0];
                        end
                        KW'(6): begin
                            if (r_state == S_CRC) r_c[2] <= sh[CW-1:0];
                            else                  r_v[2] <= sh[VW-1:0];
                        end
                        default: begin
                        end
                    endcase
                    if (r_k == K_CR_LAST) begin
                        r_k <= '0;
                        if (r_state == S_CRV) begin
                            r_state <= S_TRN;
                        end else if ((r_c[0] == '0) && (r_c[1] == '0)
                                     && (sh[CW-1:0] == '0)) begin
                            // cross of up with the gaze is zero: identity rows
                            r_degen <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SQC;
                        end
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_TRN: begin
                    case (r_k)
                        KW'(3):  r_t[0] <= sat;
                        KW'(6):  r_t[1] <= sat;
                        KW'(9):  r_t[2] <= sat;
                        default: begin
                        end
                    endcase
                    if (r_k == K_TR_LAST) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_res   <= n_res;
                    if (r_k == K_ROW_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/look_at_view_matrix_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Fixed-point look-at view matrix, one 4x4 matrix per command word.
// ----------------------------------------------------------------------------
// A command word (eye, center, up in signed fixed point with FRAC_BITS
// fraction bits) is taken at a rising edge with start high and busy low.
// The block answers with four result words, rows 0 to 3 in that order, on
// consecutive cycles, each marked by o_valid for exactly one cycle; the
// receiver cannot stall them, so sample o_result whenever o_valid is high.
// Row 3 carries last_row. When the gaze or the cross of up with the gaze is
// zero, all four rows carry degenerate and form the identity. The back
// sequencer walks one shared multiply-accumulate, a one-bit-per-cycle square
// root (two roots) and a one-bit-per-cycle divider (six quotients) for each
// matrix. A zero gaze skips the math and goes straight to the rows. The front
// stage and a two-deep queue take up to three further words while a matrix is
// in progress; busy rises only when all of them are occupied.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire lavm_pkg::t_cmd    i_cmd,
    output logic                   busy,
    output logic                   o_valid,
    output lavm_pkg::t_result      o_result
);

    logic            q_push;
    logic            q_full;
    lavm_pkg::t_job  front_job;
    lavm_pkg::t_job  queue_job;
    logic            q_empty;
    logic            pop;

    // front: accept and classify, hold one word until the queue has room
    lavm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    // queue: decouple the front from the long-running back
    lavm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (queue_job)
    );

    // back: normalize, cross, translate, then emit the four rows
    lavm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for look_at_view_matrix_core.
// ----------------------------------------------------------------------------
// A list of command words (directed corner cases, then random eye, center and
// up points) feeds a clocked driver that idles a random number of cycles
// between words. Every accepted word is turned into four expected row words
// by a fixed-point look-at predictor. A clocked monitor compares each row that
// the core emits against the oldest expected row, field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC = 16;
    localparam int CLK_HALF = 6;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    lavm_pkg::t_cmd    i_cmd;
    logic              busy;
    logic              o_valid;
    lavm_pkg::t_result o_result;

    lavm_pkg::t_cmd    cmd_backlog[$];
    lavm_pkg::t_result rows_due[$];
    int                idle_left;
    int                mismatch_count;
    bit                orphan_seen;

    look_at_view_matrix_core #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point look-at predictor
    // ------------------------------------------------------------------------
    // Floor the product sums toward minus infinity, as the core does.
    function automatic longint fx_shift(longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Floor root of the sum of three squares, done on a 128-bit radicand.
    function automatic longint vec_length(longint a, longint b, longint c);
        logic [127:0] sum;
        logic [127:0] m;
        logic [127:0] root;
        logic [127:0] trial;
        longint       comp[3];
        comp[0] = a;
        comp[1] = b;
        comp[2] = c;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            m = (comp[i] < 0) ? 128'(-comp[i]) : 128'(comp[i]);
            sum += m * m;
        end
        root = '0;
        for (int k = 62; k >= 0; k--) begin
            trial = root | (128'd1 << k);
            if (trial * trial <= sum) root = trial;
        end
        return longint'(root);
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = fx_shift(a[1] * b[2] - a[2] * b[1]);
        c[1] = fx_shift(a[2] * b[0] - a[0] * b[2]);
        c[2] = fx_shift(a[0] * b[1] - a[1] * b[0]);
    endfunction

    function automatic longint eye_offset(longint e[3], longint q[3]);
        return clamp32(fx_shift(-(e[0] * q[0] + e[1] * q[1] + e[2] * q[2])));
    endfunction

    // Queue the four rows that one command word must produce.
    task automatic predict_view_rows(lavm_pkg::t_cmd c);
        longint  e[3], g[3], up[3], w[3], cr[3], u[3], v[3];
        longint  mat[4][4];
        longint  one;
        longint  g_len, c_len;
        bit      degen;
        lavm_pkg::t_result r;
        one = 64'sd1 <<< FRAC;
        e[0]  = c.eye_x;  e[1]  = c.eye_y;  e[2]  = c.eye_z;
        up[0] = c.up_x;   up[1] = c.up_y;   up[2] = c.up_z;
        g[0]  = longint'(c.center_x) - e[0];
        g[1]  = longint'(c.center_y) - e[1];
        g[2]  = longint'(c.center_z) - e[2];
        degen = 1'b0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                mat[i][j] = (i == j) ? one : 0;
        g_len = vec_length(g[0], g[1], g[2]);
        if (g_len == 0) begin
            degen = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) w[i] = -((g[i] * one) / g_len);
            cross3(up, w, cr);
            c_len = vec_length(cr[0], cr[1], cr[2]);
            if (c_len == 0) begin
                degen = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) u[i] = (cr[i] * one) / c_len;
                cross3(w, u, v);
                for (int j = 0; j < 3; j++) begin
                    mat[0][j] = clamp32(u[j]);
                    mat[1][j] = clamp32(v[j]);
                    mat[2][j] = clamp32(w[j]);
                end
                mat[0][3] = eye_offset(e, u);
                mat[1][3] = eye_offset(e, v);
                mat[2][3] = eye_offset(e, w);
            end
        end
        for (int i = 0; i < 4; i++) begin
            r.row_index  = 2'(i);
            r.col_zero   = 32'(mat[i][0]);
            r.col_one    = 32'(mat[i][1]);
            r.col_two    = 32'(mat[i][2]);
            r.col_three  = 32'(mat[i][3]);
            r.last_row   = (i == 3);
            r.degenerate = degen;
            rows_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: take the next word from the backlog after a random idle gap.
    // ------------------------------------------------------------------------
    function automatic int draw_gap();
        // At least half the gaps are zero so back-to-back stretches occur too.
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= draw_gap();
        end else if (start && !busy) begin
            predict_view_rows(i_cmd);
            // Hold start high when the next word goes out right away.
            if (idle_left == 0 && cmd_backlog.size() > 0) begin
                i_cmd     <= cmd_backlog.pop_front();
                idle_left <= draw_gap();
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
            end else if (cmd_backlog.size() > 0) begin
                i_cmd     <= cmd_backlog.pop_front();
                start     <= 1'b1;
                idle_left <= draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobed row word is checked against the oldest expected.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        lavm_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (rows_due.size() == 0) begin
                orphan_seen = 1'b1;
                if (mismatch_count < 10)
                    $display("ERROR: unexpected row word %p", o_result);
                mismatch_count++;
            end else begin
                want = rows_due.pop_front();
                if (o_result.row_index  !== want.row_index  ||
                    o_result.col_zero   !== want.col_zero   ||
                    o_result.col_one    !== want.col_one    ||
                    o_result.col_two    !== want.col_two    ||
                    o_result.col_three  !== want.col_three  ||
                    o_result.last_row   !== want.last_row   ||
                    o_result.degenerate !== want.degenerate) begin
                    if (mismatch_count < 10) begin
                        $display("ERROR: row word mismatch at %0t", $realtime);
                        $display("  expected %p", want);
                        $display("  actual   %p", o_result);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic lavm_pkg::t_cmd make_cmd(int ex, int ey, int ez,
                                                int cx, int cy, int cz,
                                                int ux, int uy, int uz);
        lavm_pkg::t_cmd c;
        c.eye_x = ex;    c.eye_y = ey;    c.eye_z = ez;
        c.center_x = cx; c.center_y = cy; c.center_z = cz;
        c.up_x = ux;     c.up_y = uy;     c.up_z = uz;
        return c;
    endfunction

    // Coordinates of moderate size: up to 16 units either way, random fraction.
    function automatic int mild_coord();
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    function automatic int any_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom) >>> $urandom_range(0, 31);
            default: return mild_coord();
        endcase
    endfunction

    initial begin
        int one;
        int mx, mn;
        lavm_pkg::t_cmd c;
        one = 1 << FRAC;
        mx  = 32'sh7fff_ffff;
        mn  = 32'sh8000_0000;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        idle_left      = 0;
        mismatch_count = 0;
        orphan_seen    = 1'b0;

        // Directed: textbook camera, eye on center, up along or against the
        // gaze, zero up, and the field extremes.
        cmd_backlog.push_back(make_cmd(0, 0, 5*one, 0, 0, 0, 0, one, 0));
        cmd_backlog.push_back(make_cmd(one, 2*one, 3*one, -one, 0, one, 0, 0, one));
        cmd_backlog.push_back(make_cmd(7*one, -3, 9, 7*one, -3, 9, 0, one, 0));
        cmd_backlog.push_back(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(0, 0, 0, 0, 4*one, 0, 0, one, 0));
        cmd_backlog.push_back(make_cmd(0, 0, 0, 0, 4*one, 0, 0, -3*one, 0));
        cmd_backlog.push_back(make_cmd(one, one, one, 2*one, 3*one, 5*one, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        cmd_backlog.push_back(make_cmd(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        cmd_backlog.push_back(make_cmd(mx, mn, mx, mn, mx, mn, mx, mx, mx));
        cmd_backlog.push_back(make_cmd(mn, 0, 0, mx, 0, 0, 0, mn, 0));
        cmd_backlog.push_back(make_cmd(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        cmd_backlog.push_back(make_cmd(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        cmd_backlog.push_back(make_cmd(-1, -1, -1, 0, 0, 0, -1, -1, -1));
        cmd_backlog.push_back(make_cmd(0, 0, 0, 1, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(0, 0, 0, 1, 0, 0, 0, 0, 1));
        cmd_backlog.push_back(make_cmd(mx, 0, 0, mn, 0, 0, 0, mx, mx));
        cmd_backlog.push_back(make_cmd(3*one, -5*one, one, -2*one, 4*one, 0, mn, mx, 1));

        // Random: mostly ordinary cameras, some degenerate ones, some noise.
        for (int n = 0; n < 500; n++) begin
            case ($urandom_range(0, 9))
                0: c = make_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
                1: begin
                    c = make_cmd(any_coord(), any_coord(), any_coord(), 0, 0, 0,
                                 any_coord(), any_coord(), any_coord());
                    c.center_x = c.eye_x;
                    c.center_y = c.eye_y;
                    c.center_z = c.eye_z;
                end
                2: begin
                    // Up along the gaze, scaled by a small integer.
                    int k;
                    c = make_cmd(mild_coord(), mild_coord(), mild_coord(),
                                 mild_coord(), mild_coord(), mild_coord(), 0, 0, 0);
                    k = $signed($urandom_range(0, 6)) - 3;
                    c.up_x = (c.center_x - c.eye_x) * k;
                    c.up_y = (c.center_y - c.eye_y) * k;
                    c.up_z = (c.center_z - c.eye_z) * k;
                end
                3, 4: c = make_cmd(any_coord(), any_coord(), any_coord(), any_coord(),
                                   any_coord(), any_coord(), any_coord(), any_coord(),
                                   any_coord());
                default: c = make_cmd(mild_coord(), mild_coord(), mild_coord(),
                                      mild_coord(), mild_coord(), mild_coord(),
                                      mild_coord(), mild_coord(), mild_coord());
            endcase
            cmd_backlog.push_back(c);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word accepted, every row seen, then let the pipe settle.
        while (cmd_backlog.size() > 0 || start || rows_due.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0 && !orphan_seen && rows_due.size() == 0) begin
            $display("** look_at_view_matrix_core: PASSED **");
        end else begin
            $display("** look_at_view_matrix_core: FAILED **");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #(2_000_000 * 2 * CLK_HALF);
        $display("** look_at_view_matrix_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/lavm_pkg.sv
rtl/lavm_front.sv
rtl/lavm_queue.sv
rtl/lavm_isqrt.sv
rtl/lavm_div.sv
rtl/lavm_back.sv
rtl/look_at_view_matrix_core.sv
tb/sv/testbench.sv
